// ----- rtl/core/bfa_pkg.sv -----
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [BIT_W-1:0]     bit_idx_t;
    typedef logic [1:0]           cmd_t;

    localparam cmd_t CMD_ALLOC = 2'd0;
    localparam cmd_t CMD_FREE  = 2'd1;
    localparam cmd_t CMD_QUERY = 2'd2;

    typedef struct packed {
        logic     found;
        bit_idx_t bit_idx;
    } find_t;

endpackage

// ----- rtl/core/bfa_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module bfa_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/bfa_word_find.sv -----
// Lowest or highest set-bit search over one free-bit word.
module bfa_word_find (
    input  bfa_pkg::word_t free_bits,
    input  logic           highest,
    output bfa_pkg::find_t find
);

    always_comb
    begin
        find.found   = |free_bits;
        find.bit_idx = '0;
        if (highest)
        begin
            for (int i = 0; i < bfa_pkg::WORD_BITS; i++)
            begin
                if (free_bits[i])
                begin
                    find.bit_idx = bfa_pkg::bit_idx_t'(i);
                end
            end
        end
        else
        begin
            for (int i = bfa_pkg::WORD_BITS - 1; i >= 0; i--)
            begin
                if (free_bits[i])
                begin
                    find.bit_idx = bfa_pkg::bit_idx_t'(i);
                end
            end
        end
    end

endmodule

// ----- rtl/core/bitmap_frame_allocator_top.sv -----
// Top level of the first-fit bitmap page frame allocator.
//
// Usage: drive command and frame_address with start high; the item is taken
// at a clock edge where start is high and busy is low. Each item gives one
// result: done is high for exactly one cycle with result_address and ok.
// The receiver cannot stall; a result must be captured in its done cycle.
// Allocate scans the used-frame bitmap upward one 32-bit word per cycle out
// of a synchronous RAM; query scans downward from the top usable word.
// Allocate and query stop at the first free bit or after the last of the W
// usable words (32 for the default sizes), reading one word at a time.
// Free reads one word and then writes it back before done.
// An out-of-range free or an unknown command gives done on the next cycle
// without raising busy. busy is high while a scan or write-back runs.
// After reset the block clears the bitmap one word per cycle, all W words,
// with busy high; every frame is then free.
module bitmap_frame_allocator_top #(
    parameter int NUM_FRAMES = 1024,
    parameter int PAGE_SHIFT = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] frame_address,
    output logic        done,
    output logic [31:0] result_address,
    output logic        ok
);

    localparam int FIT        = 1 << (32 - PAGE_SHIFT);
    localparam int LIMIT      = (NUM_FRAMES < FIT) ? NUM_FRAMES : FIT;
    localparam int USED_WORDS = (LIMIT + 31) / 32;
    localparam int AW         = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(USED_WORDS - 1);
    localparam logic [31:0]   LIMIT_W  = 32'(LIMIT);
    localparam bfa_pkg::word_t LAST_MASK =
        ((LIMIT % 32) == 0) ? '1 : ((32'd1 << (LIMIT % 32)) - 32'd1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FREE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     chk_reg, chk_next;
    bfa_pkg::cmd_t     cmd_reg, cmd_next;
    bfa_pkg::bit_idx_t bit_reg, bit_next;
    logic              done_reg, done_next;
    logic [31:0]       result_address_reg, result_address_next;
    logic              ok_reg, ok_next;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    bfa_pkg::word_t    ram_wdata, ram_rdata;
    bfa_pkg::word_t    free_bits;
    bfa_pkg::find_t    find;
    logic [31:0]       free_frame;
    logic              at_end;

    bfa_ram #(
        .WIDTH (bfa_pkg::WORD_BITS),
        .DEPTH (USED_WORDS),
        .ADDR_W(AW)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign free_bits = ~ram_rdata & ((chk_reg == LAST_IDX) ? LAST_MASK : '1);

    bfa_word_find u_find (
        .free_bits(free_bits),
        .highest  (cmd_reg == bfa_pkg::CMD_QUERY),
        .find     (find)
    );

    assign free_frame = frame_address >> PAGE_SHIFT;
    assign at_end     = (cmd_reg == bfa_pkg::CMD_QUERY) ? (chk_reg == '0)
                                                        : (chk_reg == LAST_IDX);

    always_comb
    begin
        state_next          = state_reg;
        chk_next            = chk_reg;
        cmd_next            = cmd_reg;
        bit_next            = bit_reg;
        done_next           = 1'b0;
        result_address_next = '0;
        ok_next             = 1'b0;
        ram_we              = 1'b0;
        ram_waddr           = chk_reg;
        ram_wdata           = '0;
        ram_re              = 1'b0;
        ram_raddr           = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (chk_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    chk_next = chk_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    case (command)
                        bfa_pkg::CMD_ALLOC:
                        begin
                            chk_next   = '0;
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            state_next = ST_SCAN;
                        end
                        bfa_pkg::CMD_QUERY:
                        begin
                            chk_next   = LAST_IDX;
                            ram_re     = 1'b1;
                            ram_raddr  = LAST_IDX;
                            state_next = ST_SCAN;
                        end
                        bfa_pkg::CMD_FREE:
                        begin
                            if (free_frame < LIMIT_W)
                            begin
                                chk_next   = free_frame[AW+4:5];
                                bit_next   = free_frame[4:0];
                                ram_re     = 1'b1;
                                ram_raddr  = free_frame[AW+4:5];
                                state_next = ST_FREE;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (find.found)
                begin
                    if (cmd_reg == bfa_pkg::CMD_ALLOC)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | (bfa_pkg::word_t'(1) << find.bit_idx);
                    end
                    done_next           = 1'b1;
                    ok_next             = 1'b1;
                    result_address_next = 32'({chk_reg, find.bit_idx}) << PAGE_SHIFT;
                    state_next          = ST_IDLE;
                end
                else if (at_end)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    chk_next  = (cmd_reg == bfa_pkg::CMD_QUERY) ? chk_reg - 1'b1
                                                                : chk_reg + 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = chk_next;
                end
            end
            ST_FREE:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata & ~(bfa_pkg::word_t'(1) << bit_reg);
                done_next  = 1'b1;
                ok_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            chk_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chk_reg   <= chk_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg            <= cmd_next;
        bit_reg            <= bit_next;
        result_address_reg <= result_address_next;
        ok_reg             <= ok_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign result_address = result_address_reg;
    assign ok             = ok_reg;

    a_addr_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result_address != 32'd0) |-> ok)
        else $error("nonzero result address without ok");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted item neither in progress nor answered");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !done)
        else $error("result during bitmap clear");

    a_scan_write_alloc_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && ram_we |-> (cmd_reg == bfa_pkg::CMD_ALLOC) && done_next)
        else $error("bitmap written during scan outside allocate");

endmodule

// ----- tb/tb_bitmap_frame_allocator_top.sv -----
// Self-checking testbench for the bitmap frame allocator: directed, exhaustion, random, drain.
module tb_bitmap_frame_allocator_top;

    localparam int NUM_FRAMES   = 1024;
    localparam int PAGE_SHIFT   = 12;
    localparam int MAP_WORDS    = (NUM_FRAMES + 31) / 32;
    localparam longint FIT      = longint'(1) << (32 - PAGE_SHIFT);
    localparam int USABLE       = (NUM_FRAMES < FIT) ? NUM_FRAMES : int'(FIT);
    localparam logic [31:0] PAGE_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;
    localparam bfa_pkg::cmd_t CMD_BAD = 2'd3;
    localparam int N_RANDOM     = 120;
    localparam int N_DRAIN      = 64;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int MAX_REPORTS  = 50;

    typedef struct {
        bfa_pkg::cmd_t cmd;
        logic [31:0]   addr;
        logic          ok;
    } alloc_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  command = bfa_pkg::CMD_ALLOC;
    logic [31:0] frame_address = '0;
    logic        busy;
    logic        done;
    logic [31:0] result_address;
    logic        ok;

    bfa_pkg::word_t frame_map [MAP_WORDS];
    int             free_count;
    int             held_frames [$];
    alloc_result_t  expected_results [$];

    int err_count = 0;
    int cycles = 0;
    int burst_left = 0;
    int n_items = 0;
    int n_alloc = 0;
    int n_alloc_fail = 0;
    int n_free = 0;
    int n_free_bad = 0;
    int n_query = 0;
    int n_query_empty = 0;
    int n_unknown = 0;
    int n_results = 0;

    bitmap_frame_allocator_top #(
        .NUM_FRAMES(NUM_FRAMES),
        .PAGE_SHIFT(PAGE_SHIFT)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .frame_address(frame_address),
        .done(done),
        .result_address(result_address),
        .ok(ok)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] frame_addr(int f);
        logic [63:0] wide;
        wide = 64'(f) << PAGE_SHIFT;
        return wide[31:0];
    endfunction

    function automatic logic [31:0] addr_in_frame(int f);
        return frame_addr(f) | ($urandom & PAGE_MASK);
    endfunction

    // Advance the frame map by one item and return the result it gives.
    function automatic alloc_result_t apply_command(bfa_pkg::cmd_t c, logic [31:0] a);
        alloc_result_t r;
        int f;
        r.cmd  = c;
        r.addr = '0;
        r.ok   = 1'b0;
        f = -1;
        case (c)
            bfa_pkg::CMD_ALLOC:
            begin
                n_alloc++;
                for (int i = 0; i < USABLE; i++)
                    if (f < 0 && !frame_map[i / 32][i % 32])
                        f = i;
                if (f >= 0)
                begin
                    frame_map[f / 32][f % 32] = 1'b1;
                    free_count--;
                    held_frames.push_back(f);
                    r.addr = frame_addr(f);
                    r.ok   = 1'b1;
                end
                else
                    n_alloc_fail++;
            end
            bfa_pkg::CMD_FREE:
            begin
                n_free++;
                f = int'(a >> PAGE_SHIFT);
                if (f < USABLE)
                begin
                    if (frame_map[f / 32][f % 32])
                    begin
                        frame_map[f / 32][f % 32] = 1'b0;
                        free_count++;
                    end
                    r.ok = 1'b1;
                end
                else
                    n_free_bad++;
            end
            bfa_pkg::CMD_QUERY:
            begin
                n_query++;
                for (int i = USABLE - 1; i >= 0; i--)
                    if (f < 0 && !frame_map[i / 32][i % 32])
                        f = i;
                if (f >= 0)
                begin
                    r.addr = frame_addr(f);
                    r.ok   = 1'b1;
                end
                else
                    n_query_empty++;
            end
            default:
                n_unknown++;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // Hold the item until taken, then predict it and idle between bursts.
    task automatic send_item(bfa_pkg::cmd_t c, logic [31:0] a);
        int gap;
        start         <= 1'b1;
        command       <= c;
        frame_address <= a;
        do
            @(posedge clk);
        while (busy);
        expected_results.push_back(apply_command(c, a));
        n_items++;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
        else
            burst_left--;
    endtask

    always @(posedge clk)
    begin
        alloc_result_t e;
        if (done)
        begin
            n_results++;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result with none expected: addr %h ok %b",
                                          result_address, ok));
            else
            begin
                e = expected_results.pop_front();
                if (result_address !== e.addr)
                    report_mismatch($sformatf("cmd %0d result_address %h, expected %h",
                                              e.cmd, result_address, e.addr));
                if (ok !== e.ok)
                    report_mismatch($sformatf("cmd %0d ok %b, expected %b",
                                              e.cmd, ok, e.ok));
            end
        end
    end

    task automatic test_directed();
        send_item(bfa_pkg::CMD_ALLOC, 32'h0000_0000);
        send_item(bfa_pkg::CMD_ALLOC, 32'h0000_0000);
        send_item(bfa_pkg::CMD_QUERY, 32'h0000_0000);
        send_item(bfa_pkg::CMD_FREE,  32'h0000_0000);
        send_item(bfa_pkg::CMD_FREE,  32'h0000_0000);
        send_item(bfa_pkg::CMD_ALLOC, 32'h0000_0000);
        send_item(bfa_pkg::CMD_FREE,  frame_addr(1) | PAGE_MASK);
        send_item(bfa_pkg::CMD_FREE,  frame_addr(USABLE));
        send_item(bfa_pkg::CMD_FREE,  32'hFFFF_FFFF);
        send_item(bfa_pkg::CMD_FREE,  frame_addr(USABLE - 1) | PAGE_MASK);
        send_item(CMD_BAD,            32'hFFFF_FFFF);
        send_item(CMD_BAD,            32'h0000_0000);
        send_item(bfa_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
        send_item(bfa_pkg::CMD_QUERY, 32'hFFFF_FFFF);
        send_item(bfa_pkg::CMD_FREE,  32'h8000_0000);
        send_item(bfa_pkg::CMD_FREE,  32'h7FFF_FFFF);
    endtask

    task automatic test_exhaustion();
        while (free_count > 0)
            send_item(bfa_pkg::CMD_ALLOC, $urandom);
        send_item(bfa_pkg::CMD_QUERY, $urandom);
        send_item(bfa_pkg::CMD_ALLOC, $urandom);
        send_item(CMD_BAD,            $urandom);
        send_item(bfa_pkg::CMD_FREE,  addr_in_frame(USABLE - 1));
        send_item(bfa_pkg::CMD_QUERY, $urandom);
        send_item(bfa_pkg::CMD_FREE,  addr_in_frame(500 % USABLE));
        send_item(bfa_pkg::CMD_FREE,  addr_in_frame(37 % USABLE));
        send_item(bfa_pkg::CMD_ALLOC, $urandom);
        send_item(bfa_pkg::CMD_ALLOC, $urandom);
        send_item(bfa_pkg::CMD_ALLOC, $urandom);
        send_item(bfa_pkg::CMD_ALLOC, $urandom);
        send_item(bfa_pkg::CMD_QUERY, $urandom);
    endtask

    task automatic test_random();
        int r;
        int idx;
        int alloc_weight;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            alloc_weight = (i < N_RANDOM / 2) ? 40 : 25;
            r = $urandom_range(0, 99);
            if (r < alloc_weight || (r < 70 && held_frames.size() == 0))
                send_item(bfa_pkg::CMD_ALLOC, $urandom);
            else if (r < 70)
            begin
                idx = $urandom_range(0, held_frames.size() - 1);
                send_item(bfa_pkg::CMD_FREE, addr_in_frame(held_frames[idx]));
                held_frames.delete(idx);
            end
            else if (r < 78)
                send_item(bfa_pkg::CMD_FREE, addr_in_frame($urandom_range(0, USABLE - 1)));
            else if (r < 85)
                send_item(bfa_pkg::CMD_FREE, $urandom);
            else if (r < 97)
                send_item(bfa_pkg::CMD_QUERY, $urandom);
            else
                send_item(CMD_BAD, $urandom);
        end
    endtask

    task automatic test_drain();
        for (int i = 0; i < N_DRAIN; i++)
            send_item(bfa_pkg::CMD_FREE, addr_in_frame((i * 37) % USABLE));
        send_item(bfa_pkg::CMD_QUERY, $urandom);
        send_item(bfa_pkg::CMD_ALLOC, $urandom);
    endtask

    initial
    begin
        for (int w = 0; w < MAP_WORDS; w++)
            frame_map[w] = '0;
        free_count = USABLE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_exhaustion();
        test_random();
        test_drain();

        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2 * MAP_WORDS + 8) @(posedge clk);

        $display("covered %0d items, %0d results: %0d allocations (%0d with pool full),",
                 n_items, n_results, n_alloc, n_alloc_fail);
        $display("  %0d frees (%0d out of range), %0d queries (%0d empty), %0d unknown",
                 n_free, n_free_bad, n_query, n_query_empty, n_unknown);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/bfa_pkg.sv
rtl/core/bfa_ram.sv
rtl/core/bfa_word_find.sv
rtl/core/bitmap_frame_allocator_top.sv
tb/tb_bitmap_frame_allocator_top.sv
